@@ rtl/b64e_pkg.sv @@
// shared types, constants and the alphabet lookup for the base64 stream encoder
`default_nettype none
package b64e_pkg;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       group_end;
    logic       stream_end;
  } char_item_t;

  // one group of up to three bytes waiting to be serialized
  typedef struct packed {
    logic [23:0] bits24;
    logic [2:0]  nchars;
    logic        last;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t group;
  } group_push_t;

  typedef struct packed {
    logic   valid;
    logic   full;
    group_t group;
  } queue_status_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      r = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/b64e_front.sv @@
// input side: collects bytes into groups and pushes finished groups
`default_nettype none
module b64e_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire b64e_pkg::byte_item_t byte_item,
  input  wire logic                queue_full,
  output b64e_pkg::group_push_t    push
);
  import b64e_pkg::*;

  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  held_count, held_count_next;
  logic        accept;
  logic [15:0] merged;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    merged          = (held_count == 2'd0) ? {byte_item.data_byte, 8'h00}
                                           : {held_bytes[15:8], byte_item.data_byte};
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    push            = '0;
    if (accept) begin
      if (held_count >= 2'd2) begin
        push.valid        = 1'b1;
        push.group.bits24 = {held_bytes, byte_item.data_byte};
        push.group.nchars = 3'd4;
        push.group.last   = byte_item.final_byte;
        held_bytes_next   = '0;
        held_count_next   = '0;
      end else if (byte_item.final_byte) begin
        push.valid        = 1'b1;
        push.group.bits24 = {merged, 8'h00};
        push.group.nchars = {1'b0, held_count} + 3'd2;
        push.group.last   = 1'b1;
        held_bytes_next   = '0;
        held_count_next   = '0;
      end else begin
        held_bytes_next = merged;
        held_count_next = held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= '0;
    end else begin
      held_bytes <= held_bytes_next;
      held_count <= held_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/b64e_queue.sv @@
// short group queue between the byte side and the character side
`default_nettype none
module b64e_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire b64e_pkg::group_push_t push,
  input  wire logic                  pop,
  output b64e_pkg::queue_status_t    status
);
  import b64e_pkg::*;

  group_t                entries [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr, rd_ptr;
  logic [QueueCntW-1:0]  count;
  logic                  do_push, do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == QueueCntW'(QueueDepth));
  assign status.group = entries[rd_ptr];
  assign do_push      = push.valid && !status.full;
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QueueCntW'(do_push) - QueueCntW'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/b64e_back.sv @@
// output side: serializes one group into four characters through an output register
`default_nettype none
module b64e_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire b64e_pkg::queue_status_t status,
  output logic                         pop,
  output logic                         char_valid,
  input  wire logic                    char_ready,
  output b64e_pkg::char_item_t         char_item
);
  import b64e_pkg::*;

  logic [1:0]  char_idx;
  logic        load;
  logic [5:0]  sextet;
  char_item_t  char_next;

  assign load = status.valid && (!char_valid || char_ready);
  assign pop  = load && (char_idx == 2'd3);

  always_comb begin
    sextet = 6'(status.group.bits24 >> (5'd18 - 5'd6 * {3'b000, char_idx}));
    char_next.code_char  = ({1'b0, char_idx} < status.group.nchars)
                           ? sextet_to_char(sextet) : PadChar;
    char_next.group_end  = (char_idx == 2'd3);
    char_next.stream_end = (char_idx == 2'd3) && status.group.last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_item <= char_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      char_idx   <= '0;
    end else begin
      if (load) begin
        char_valid <= 1'b1;
        char_idx   <= char_idx + 2'd1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/base64_stream_encoder.sv @@
// base64 stream encoder top level: byte front, group queue, character back
// a group is written into the group queue, then its first character goes through the output register
// throughput: one character per cycle while a group is queued and char_ready is high; 3 bytes give 4 characters
// bytes are taken every cycle while the two-entry group queue has room
// synchronous active-high reset clears held bytes, queue and output valid
`default_nettype none
module base64_stream_encoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_ready,
  input  wire b64e_pkg::byte_item_t byte_item,
  output logic                      char_valid,
  input  wire logic                 char_ready,
  output b64e_pkg::char_item_t      char_item
);
  import b64e_pkg::*;

  group_push_t   push;
  queue_status_t status;
  logic          pop;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .queue_full (status.full),
    .push       (push)
  );

  b64e_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .status (status)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .status     (status),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

endmodule
`default_nettype wire

@@ rtl/b64e_checker.sv @@
// port-level checks for the base64 stream encoder, bound to the top level
`default_nettype none
module b64e_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 char_valid,
  input wire logic                 char_ready,
  input wire b64e_pkg::char_item_t char_item
);
  import b64e_pkg::*;

  // stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_item))
    else $error("output transaction changed while stalled");

  a_stream_in_group: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_item.stream_end |-> char_item.group_end)
    else $error("stream end outside a group end");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !char_valid)
    else $error("output valid right after reset");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    char_valid |->
      (char_item.code_char >= 8'h41 && char_item.code_char <= 8'h5A) ||
      (char_item.code_char >= 8'h61 && char_item.code_char <= 8'h7A) ||
      (char_item.code_char >= 8'h30 && char_item.code_char <= 8'h39) ||
      char_item.code_char == 8'h2B || char_item.code_char == 8'h2F ||
      char_item.code_char == PadChar)
    else $error("character outside the alphabet");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .char_item  (char_item)
);
`default_nettype wire
